// ===== hw/rtl/acfd_pkg.sv =====
// ----------------------------------------------------------------------------
// acfd_pkg
// Shared types, codes and helpers of the arm command frame decoder.
// ----------------------------------------------------------------------------
package acfd_pkg;

    // Widths and sizes
    localparam int ID_W            = 11;
    localparam int LEN_W           = 4;
    localparam int VAL_W           = 16;
    localparam int APB_ADDR_W      = 5;
    localparam int APB_DATA_W      = 32;
    localparam int S_TDATA_W       = 80;
    localparam int M_TDATA_W       = 120;
    localparam int M_TUSER_W       = 2;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Frame kind reported with every result
    typedef enum logic [1:0] {
        KIND_CMD   = 2'd0,
        KIND_SETUP = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_OTHER = 2'd3
    } t_kind;

    // Operation handed from the front end to the back end
    typedef enum logic [2:0] {
        OP_NONE,
        OP_MULTI,
        OP_INCR,
        OP_ABS,
        OP_HOME,
        OP_SPEED,
        OP_LOCK,
        OP_UNLOCK
    } t_op;

    // Command and setup codes carried in byte 0
    localparam logic [7:0] CMD_MULTI    = 8'h12;
    localparam logic [7:0] CMD_INCR     = 8'h21;
    localparam logic [7:0] SETUP_HOME   = 8'h01;
    localparam logic [7:0] SETUP_SPEED  = 8'h02;
    localparam logic [7:0] SETUP_LOCK   = 8'h03;
    localparam logic [7:0] SETUP_UNLOCK = 8'h04;

    // Joint mask bits of a multi-joint command
    localparam int MASK_J0   = 0;
    localparam int MASK_J1   = 1;
    localparam int MASK_J2   = 2;
    localparam int MASK_GRIP = 3;

    // Joint numbers of incremental and absolute commands
    localparam logic [7:0] JNT_BASE = 8'd0;
    localparam logic [7:0] JNT_ONE  = 8'd1;
    localparam logic [7:0] JNT_TWO  = 8'd2;
    localparam logic [7:0] JNT_GRIP = 8'd3;

    // Minimum frame lengths
    localparam logic [LEN_W-1:0] MIN_CMD_LEN   = 4'd4;
    localparam logic [LEN_W-1:0] MIN_SETUP_LEN = 4'd1;
    localparam logic [LEN_W-1:0] MIN_SPEED_LEN = 4'd3;

    // Gripper constants
    localparam logic [VAL_W-1:0] GRIP_OPEN      = 16'd5000;
    localparam logic [7:0]       GRIP_LEVEL_MAX = 8'd200;
    localparam logic [VAL_W-1:0] HOME_GRIP_L2   = 16'd3200;
    localparam logic [VAL_W-1:0] HOME_GRIP_L1   = 16'd3000;

    // Layout codes
    localparam logic [1:0] LAYOUT_ARM = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_COMMAND_ID = 3'd0;
    localparam logic [2:0] REG_SETUP_ID   = 3'd1;
    localparam logic [2:0] REG_QUERY_ID   = 3'd2;
    localparam logic [2:0] REG_LAYOUT     = 3'd3;
    localparam logic [2:0] REG_J1_MIN     = 3'd4;
    localparam logic [2:0] REG_J1_MAX     = 3'd5;
    localparam logic [2:0] REG_J2_MIN     = 3'd6;
    localparam logic [2:0] REG_J2_MAX     = 3'd7;

    // Register reset values
    localparam logic [ID_W-1:0]  RST_COMMAND_ID = 11'h130;
    localparam logic [ID_W-1:0]  RST_SETUP_ID   = 11'h430;
    localparam logic [ID_W-1:0]  RST_QUERY_ID   = 11'h230;
    localparam logic [1:0]       RST_LAYOUT     = 2'd2;
    localparam logic [VAL_W-1:0] RST_LIMIT_LO   = 16'hFC7C;  // -900
    localparam logic [VAL_W-1:0] RST_LIMIT_HI   = 16'h0384;  //  900

    // Configuration seen by front and back end
    typedef struct packed {
        logic [ID_W-1:0]  command_id;
        logic [ID_W-1:0]  setup_id;
        logic [ID_W-1:0]  query_id;
        logic [1:0]       layout;
        logic [VAL_W-1:0] j1_min;
        logic [VAL_W-1:0] j1_max;
        logic [VAL_W-1:0] j2_min;
        logic [VAL_W-1:0] j2_max;
    } t_cfg;

    // Decoded item queued between front and back end
    typedef struct packed {
        t_kind            kind;
        t_op              op;
        logic             arm;       // two joints plus gripper layout
        logic [7:0]       sel;       // joint number or joint mask
        logic [VAL_W-1:0] value;     // bytes 3:2
        logic [VAL_W-1:0] value2;    // bytes 5:4
        logic [VAL_W-1:0] base8;     // byte 7 sign extended
        logic [VAL_W-1:0] grip_abs;  // gripper target from byte 6
        logic [VAL_W-1:0] speed;     // bytes 2:1
    } t_item;

    // Servo targets and flags
    typedef struct packed {
        logic [VAL_W-1:0] base;
        logic [VAL_W-1:0] a1;
        logic [VAL_W-1:0] a2;
        logic [VAL_W-1:0] grip;
        logic [VAL_W-1:0] left;
        logic [VAL_W-1:0] right;
        logic [VAL_W-1:0] rate;
        logic             active;
        logic             lock;
    } t_targets;

    // Sign-extend a 16-bit value by one bit
    function automatic logic signed [VAL_W:0] sx17(input logic [VAL_W-1:0] v);
        return $signed({v[VAL_W-1], v});
    endfunction

    // Raise to the minimum first, then cut to the maximum
    function automatic logic [VAL_W-1:0] clamp(input logic signed [VAL_W:0] v,
                                               input logic [VAL_W-1:0]     lo,
                                               input logic [VAL_W-1:0]     hi);
        logic signed [VAL_W:0] t;
        t = v;
        if (t < sx17(lo)) t = sx17(lo);
        if (t > sx17(hi)) t = sx17(hi);
        return t[VAL_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/acfd_regs.sv =====
// ----------------------------------------------------------------------------
// acfd_regs
// APB register file holding frame ids, layout and joint limits.
// ----------------------------------------------------------------------------
module acfd_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [acfd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [acfd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [acfd_pkg::APB_DATA_W-1:0]   prdata,
    output acfd_pkg::t_cfg                    o_cfg
);

    acfd_pkg::t_cfg r_cfg;
    logic [2:0]     idx;
    logic           wr_en;

    assign idx   = paddr[acfd_pkg::APB_ADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;
    assign o_cfg = r_cfg;

    // Write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.command_id <= acfd_pkg::RST_COMMAND_ID;
            r_cfg.setup_id   <= acfd_pkg::RST_SETUP_ID;
            r_cfg.query_id   <= acfd_pkg::RST_QUERY_ID;
            r_cfg.layout     <= acfd_pkg::RST_LAYOUT;
            r_cfg.j1_min     <= acfd_pkg::RST_LIMIT_LO;
            r_cfg.j1_max     <= acfd_pkg::RST_LIMIT_HI;
            r_cfg.j2_min     <= acfd_pkg::RST_LIMIT_LO;
            r_cfg.j2_max     <= acfd_pkg::RST_LIMIT_HI;
        end else if (wr_en) begin
            unique case (idx)
                acfd_pkg::REG_COMMAND_ID: r_cfg.command_id <= pwdata[acfd_pkg::ID_W-1:0];
                acfd_pkg::REG_SETUP_ID:   r_cfg.setup_id   <= pwdata[acfd_pkg::ID_W-1:0];
                acfd_pkg::REG_QUERY_ID:   r_cfg.query_id   <= pwdata[acfd_pkg::ID_W-1:0];
                acfd_pkg::REG_LAYOUT:     r_cfg.layout     <= pwdata[1:0];
                acfd_pkg::REG_J1_MIN:     r_cfg.j1_min     <= pwdata[acfd_pkg::VAL_W-1:0];
                acfd_pkg::REG_J1_MAX:     r_cfg.j1_max     <= pwdata[acfd_pkg::VAL_W-1:0];
                acfd_pkg::REG_J2_MIN:     r_cfg.j2_min     <= pwdata[acfd_pkg::VAL_W-1:0];
                acfd_pkg::REG_J2_MAX:     r_cfg.j2_max     <= pwdata[acfd_pkg::VAL_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back, limits sign extended
    always_comb begin
        unique case (idx)
            acfd_pkg::REG_COMMAND_ID: prdata = {21'd0, r_cfg.command_id};
            acfd_pkg::REG_SETUP_ID:   prdata = {21'd0, r_cfg.setup_id};
            acfd_pkg::REG_QUERY_ID:   prdata = {21'd0, r_cfg.query_id};
            acfd_pkg::REG_LAYOUT:     prdata = {30'd0, r_cfg.layout};
            acfd_pkg::REG_J1_MIN:     prdata = {{16{r_cfg.j1_min[15]}}, r_cfg.j1_min};
            acfd_pkg::REG_J1_MAX:     prdata = {{16{r_cfg.j1_max[15]}}, r_cfg.j1_max};
            acfd_pkg::REG_J2_MIN:     prdata = {{16{r_cfg.j2_min[15]}}, r_cfg.j2_min};
            acfd_pkg::REG_J2_MAX:     prdata = {{16{r_cfg.j2_max[15]}}, r_cfg.j2_max};
            default:                  prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/acfd_front.sv =====
// ----------------------------------------------------------------------------
// acfd_front
// Accept a frame, classify it by id and length, and decode its operation.
// ----------------------------------------------------------------------------
module acfd_front (
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [acfd_pkg::S_TDATA_W-1:0]     i_s_tdata,
    input  acfd_pkg::t_cfg                     i_cfg,
    input  logic                               i_full,
    output logic                               o_push,
    output acfd_pkg::t_item                    o_item
);

    logic [acfd_pkg::ID_W-1:0]  id;
    logic [acfd_pkg::LEN_W-1:0] len;
    logic [7:0]                 b [8];
    logic [7:0]                 grip_level;
    logic [acfd_pkg::VAL_W-1:0] grip_ten;
    logic                       cmd_hit;
    logic                       setup_hit;
    logic                       query_hit;

    // Unpack fields
    assign id  = i_s_tdata[10:0];
    assign len = i_s_tdata[14:11];
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            b[k] = i_s_tdata[15 + 8*k +: 8];
        end
    end

    // Accept whenever the queue has room
    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;

    assign cmd_hit   = (id == i_cfg.command_id) && (len >= acfd_pkg::MIN_CMD_LEN);
    assign setup_hit = (id == i_cfg.setup_id) && (len >= acfd_pkg::MIN_SETUP_LEN);
    assign query_hit = (id == i_cfg.query_id);

    // Gripper level saturates at 200, target is open minus ten per step
    assign grip_level = (b[6] > acfd_pkg::GRIP_LEVEL_MAX) ? acfd_pkg::GRIP_LEVEL_MAX : b[6];
    assign grip_ten   = ({8'd0, grip_level} << 3) + ({8'd0, grip_level} << 1);

    // Decode
    always_comb begin
        o_item.arm      = (i_cfg.layout == acfd_pkg::LAYOUT_ARM);
        o_item.sel      = b[1];
        o_item.value    = {b[3], b[2]};
        o_item.value2   = {b[5], b[4]};
        o_item.base8    = {{8{b[7][7]}}, b[7]};
        o_item.grip_abs = acfd_pkg::GRIP_OPEN - grip_ten;
        o_item.speed    = {b[2], b[1]};
        o_item.kind     = acfd_pkg::KIND_OTHER;
        o_item.op       = acfd_pkg::OP_NONE;
        priority if (cmd_hit) begin
            o_item.kind = acfd_pkg::KIND_CMD;
            priority if (b[0] == acfd_pkg::CMD_MULTI) o_item.op = acfd_pkg::OP_MULTI;
            else if (b[0] == acfd_pkg::CMD_INCR)      o_item.op = acfd_pkg::OP_INCR;
            else                                      o_item.op = acfd_pkg::OP_ABS;
        end else if (setup_hit) begin
            o_item.kind = acfd_pkg::KIND_SETUP;
            unique case (b[0])
                acfd_pkg::SETUP_HOME:   o_item.op = acfd_pkg::OP_HOME;
                acfd_pkg::SETUP_SPEED:  o_item.op = (len >= acfd_pkg::MIN_SPEED_LEN)
                                                    ? acfd_pkg::OP_SPEED : acfd_pkg::OP_NONE;
                acfd_pkg::SETUP_LOCK:   o_item.op = acfd_pkg::OP_LOCK;
                acfd_pkg::SETUP_UNLOCK: o_item.op = acfd_pkg::OP_UNLOCK;
                default:                o_item.op = acfd_pkg::OP_NONE;
            endcase
        end else if (query_hit) begin
            o_item.kind = acfd_pkg::KIND_QUERY;
        end else begin
            o_item.kind = acfd_pkg::KIND_OTHER;
        end
    end

endmodule

// ===== hw/rtl/acfd_queue.sv =====
// ----------------------------------------------------------------------------
// acfd_queue
// Short ring queue of decoded items between front and back end.
// ----------------------------------------------------------------------------
module acfd_queue #(
    parameter int DEPTH = acfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  acfd_pkg::t_item   i_item,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output acfd_pkg::t_item   o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    acfd_pkg::t_item  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== hw/rtl/acfd_back.sv =====
// ----------------------------------------------------------------------------
// acfd_back
// Apply decoded items to the servo targets and present one result per item.
// ----------------------------------------------------------------------------
module acfd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  acfd_pkg::t_cfg       i_cfg,
    input  logic                 i_valid,
    input  acfd_pkg::t_item      i_item,
    output logic                 o_pop,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output acfd_pkg::t_kind      o_kind,
    output acfd_pkg::t_targets   o_tgt
);

    acfd_pkg::t_targets         r_tgt;
    acfd_pkg::t_targets         n_tgt;
    acfd_pkg::t_kind            r_kind;
    logic                       r_valid;
    logic [acfd_pkg::VAL_W:0]   inc1;
    logic [acfd_pkg::VAL_W:0]   inc2;
    logic [acfd_pkg::VAL_W-1:0] grip_sum;

    // Take the next item once the result slot is free or being drained
    assign o_pop      = i_valid && (!r_valid || i_m_tready);
    assign o_m_tvalid = r_valid;
    assign o_kind     = r_kind;
    assign o_tgt      = r_tgt;

    assign inc1     = acfd_pkg::sx17(r_tgt.a1) + acfd_pkg::sx17(i_item.value);
    assign inc2     = acfd_pkg::sx17(r_tgt.a2) + acfd_pkg::sx17(i_item.value);
    assign grip_sum = r_tgt.grip + i_item.value;

    // Next targets
    always_comb begin
        n_tgt = r_tgt;
        unique case (i_item.op)
            acfd_pkg::OP_MULTI: begin
                n_tgt.active = 1'b1;
                if (i_item.sel[acfd_pkg::MASK_J0]) n_tgt.base = i_item.base8;
                if (i_item.sel[acfd_pkg::MASK_J1]) begin
                    n_tgt.a1 = i_item.arm
                        ? acfd_pkg::clamp(acfd_pkg::sx17(i_item.value),
                                          i_cfg.j1_min, i_cfg.j1_max)
                        : i_item.value;
                end
                if (i_item.sel[acfd_pkg::MASK_J2]) begin
                    n_tgt.a2 = i_item.arm
                        ? acfd_pkg::clamp(acfd_pkg::sx17(i_item.value2),
                                          i_cfg.j2_min, i_cfg.j2_max)
                        : i_item.value2;
                end
                if (i_item.sel[acfd_pkg::MASK_GRIP]) n_tgt.grip = i_item.grip_abs;
            end
            acfd_pkg::OP_INCR: begin
                n_tgt.active = 1'b1;
                if (i_item.arm) begin
                    if (i_item.sel == acfd_pkg::JNT_ONE) begin
                        n_tgt.a1 = acfd_pkg::clamp(inc1, i_cfg.j1_min, i_cfg.j1_max);
                    end else if (i_item.sel == acfd_pkg::JNT_TWO) begin
                        n_tgt.a2 = acfd_pkg::clamp(inc2, i_cfg.j2_min, i_cfg.j2_max);
                    end else if (i_item.sel == acfd_pkg::JNT_GRIP) begin
                        n_tgt.grip = grip_sum;
                    end
                end else if (i_item.sel == acfd_pkg::JNT_ONE
                          || i_item.sel == acfd_pkg::JNT_TWO
                          || i_item.sel == acfd_pkg::JNT_GRIP) begin
                    // twin layout: joints one, two and the gripper all move the gripper
                    n_tgt.grip = grip_sum;
                end
            end
            acfd_pkg::OP_ABS: begin
                n_tgt.active = 1'b1;
                if (i_item.sel == acfd_pkg::JNT_BASE) begin
                    n_tgt.base = i_item.value;
                end else if (i_item.sel == acfd_pkg::JNT_GRIP) begin
                    n_tgt.grip = i_item.value;
                end else if (i_item.sel == acfd_pkg::JNT_ONE) begin
                    if (i_item.arm) begin
                        n_tgt.a1 = acfd_pkg::clamp(acfd_pkg::sx17(i_item.value),
                                                   i_cfg.j1_min, i_cfg.j1_max);
                    end else begin
                        n_tgt.left = i_item.value;
                    end
                end else if (i_item.sel == acfd_pkg::JNT_TWO) begin
                    if (i_item.arm) begin
                        n_tgt.a2 = acfd_pkg::clamp(acfd_pkg::sx17(i_item.value),
                                                   i_cfg.j2_min, i_cfg.j2_max);
                    end else begin
                        n_tgt.right = i_item.value;
                    end
                end
            end
            acfd_pkg::OP_HOME: begin
                n_tgt.active = 1'b1;
                if (i_item.arm) begin
                    n_tgt.a1   = '0;
                    n_tgt.a2   = '0;
                    n_tgt.grip = acfd_pkg::HOME_GRIP_L2;
                end else begin
                    n_tgt.grip  = acfd_pkg::HOME_GRIP_L1;
                    n_tgt.left  = '0;
                    n_tgt.right = '0;
                end
            end
            acfd_pkg::OP_SPEED:  n_tgt.rate = i_item.speed;
            acfd_pkg::OP_LOCK:   n_tgt.lock = 1'b1;
            acfd_pkg::OP_UNLOCK: n_tgt.lock = 1'b0;
            acfd_pkg::OP_NONE:   ;
            default:             ;
        endcase
    end

    // Targets double as the result register: they only change on a pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt   <= '0;
            r_valid <= 1'b0;
            r_kind  <= acfd_pkg::KIND_OTHER;
        end else begin
            if (o_pop) begin
                r_tgt  <= n_tgt;
                r_kind <= i_item.kind;
            end
            if (o_pop) begin
                r_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== hw/rtl/arm_command_frame_decoder_core.sv =====
// ----------------------------------------------------------------------------
// arm_command_frame_decoder_core
// CAN frame decoder driving arm servo targets, with APB configuration.
// ----------------------------------------------------------------------------
// Path: an accepted frame is written into the queue, and the back end registers
// its targets and kind into the result slot when it pops the item at the head.
// Throughput: one frame per cycle while the result side is ready and the queue has room.
// Reset: synchronous, active low; clears all targets and flags, empties the
// queue and loads the register defaults.
module arm_command_frame_decoder_core #(
    parameter int QUEUE_DEPTH = acfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input frame
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // frame_id[10:0], frame_len[14:11], byte0[22:15], byte1[30:23],
    // byte2[38:31], byte3[46:39], byte4[54:47], byte5[62:55],
    // byte6[70:63], byte7[78:71], zero[79]
    input  logic [acfd_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // result
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // base_target[15:0], first_angle[31:16], second_angle[47:32],
    // grip_target[63:48], left_channel[79:64], right_channel[95:80],
    // rate_tenths[111:96], servo_on[112], locked_flag[113], zero[119:114]
    output logic [acfd_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // frame_kind[1:0]
    output logic [acfd_pkg::M_TUSER_W-1:0]   o_m_tuser,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [acfd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [acfd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [acfd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    acfd_pkg::t_cfg     cfg;
    acfd_pkg::t_item    push_item;
    acfd_pkg::t_item    head_item;
    acfd_pkg::t_targets tgt;
    acfd_pkg::t_kind    kind;
    logic               push;
    logic               full;
    logic               pop;
    logic               head_valid;

    assign pready = 1'b1;

    acfd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    acfd_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_cfg      (cfg),
        .i_full     (full),
        .o_push     (push),
        .o_item     (push_item)
    );

    acfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_item  (head_item)
    );

    acfd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (head_valid),
        .i_item     (head_item),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_kind     (kind),
        .o_tgt      (tgt)
    );

    // Pack the result
    assign o_m_tdata = {6'd0, tgt.lock, tgt.active, tgt.rate, tgt.right, tgt.left,
                        tgt.grip, tgt.a2, tgt.a1, tgt.base};
    assign o_m_tuser = kind;

endmodule

// ===== hw/rtl/acfd_checker.sv =====
// ----------------------------------------------------------------------------
// acfd_checker
// Port-level checks of the arm command frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module acfd_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             o_s_tready,
    input  logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [acfd_pkg::M_TDATA_W-1:0]   o_m_tdata,
    input  logic [acfd_pkg::M_TUSER_W-1:0]   o_m_tuser
);

    // Reset empties the result slot
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("stalled result changed");

    // A full queue only happens behind a blocked result
    a_full_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !$past(i_m_tready))
        else $error("input stalled without a blocked result");

    // Any joint command activates the servos
    a_cmd_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == acfd_pkg::KIND_CMD) |-> o_m_tdata[112])
        else $error("joint command without servo_on");

endmodule

bind arm_command_frame_decoder_core acfd_checker u_acfd_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the arm command frame decoder core. A scoreboard
// keeps its own copy of the servo targets and register settings, predicts
// the kind and targets reported for every accepted frame and compares them
// field by field with the results. Directed frames cover the edge cases;
// then several register settings each run a batch of random frames, with
// random result gaps, input gaps in most settings and one long result hold-off.
// ----------------------------------------------------------------------------
module testbench;

    localparam int         GRIP_SPAN    = 2000;
    localparam logic [1:0] LAYOUT_TWIN  = 2'd1;
    localparam int         PHASES       = 8;
    localparam int         PHASE_FRAMES = 112;
    localparam int         REPORT_MAX   = 10;
    localparam int         RES_W        = acfd_pkg::M_TUSER_W + acfd_pkg::M_TDATA_W;
    localparam int         ID_W         = acfd_pkg::ID_W;
    localparam int         LEN_W        = acfd_pkg::LEN_W;
    localparam int         VAL_W        = acfd_pkg::VAL_W;

    // ------------------------------------------------------------------------
    // Scoreboard: target prediction and result checking
    // ------------------------------------------------------------------------
    class arm_target_scoreboard;
        logic [ID_W-1:0]    cmd_id, setup_id, query_id;
        logic [1:0]         layout;
        logic [VAL_W-1:0]   j1_lo, j1_hi, j2_lo, j2_hi;
        acfd_pkg::t_targets tgt;
        logic [RES_W-1:0]   predicted_q[$];
        int                 failures;
        int                 results_seen;

        function new();
            cmd_id       = acfd_pkg::RST_COMMAND_ID;
            setup_id     = acfd_pkg::RST_SETUP_ID;
            query_id     = acfd_pkg::RST_QUERY_ID;
            layout       = acfd_pkg::RST_LAYOUT;
            j1_lo        = acfd_pkg::RST_LIMIT_LO;
            j1_hi        = acfd_pkg::RST_LIMIT_HI;
            j2_lo        = acfd_pkg::RST_LIMIT_LO;
            j2_hi        = acfd_pkg::RST_LIMIT_HI;
            tgt          = '0;
            failures     = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [acfd_pkg::APB_DATA_W-1:0] val);
            case (idx)
                acfd_pkg::REG_COMMAND_ID: cmd_id   = val[ID_W-1:0];
                acfd_pkg::REG_SETUP_ID:   setup_id = val[ID_W-1:0];
                acfd_pkg::REG_QUERY_ID:   query_id = val[ID_W-1:0];
                acfd_pkg::REG_LAYOUT:     layout   = val[1:0];
                acfd_pkg::REG_J1_MIN:     j1_lo    = val[VAL_W-1:0];
                acfd_pkg::REG_J1_MAX:     j1_hi    = val[VAL_W-1:0];
                acfd_pkg::REG_J2_MIN:     j2_lo    = val[VAL_W-1:0];
                acfd_pkg::REG_J2_MAX:     j2_hi    = val[VAL_W-1:0];
                default: ;
            endcase
        endfunction

        function int sx(logic [VAL_W-1:0] v);
            logic signed [VAL_W-1:0] s;
            s = v;
            return int'(s);
        endfunction

        // Raise to the minimum, then cut to the maximum; the maximum wins
        function logic [VAL_W-1:0] limit(int v, logic [VAL_W-1:0] lo,
                                         logic [VAL_W-1:0] hi);
            int r;
            r = v;
            if (r < sx(lo)) r = sx(lo);
            if (r > sx(hi)) r = sx(hi);
            return r[VAL_W-1:0];
        endfunction

        function int pending();
            return predicted_q.size();
        endfunction

        // Update the targets for one accepted frame and queue the report
        function void note_frame(logic [acfd_pkg::S_TDATA_W-1:0] d);
            logic [ID_W-1:0]  id;
            logic [LEN_W-1:0] len;
            logic [7:0]       b [0:7];
            logic [VAL_W-1:0] value, value2;
            logic             arm;
            acfd_pkg::t_kind  kind;
            int               g, k;
            id  = d[ID_W-1:0];
            len = d[ID_W +: LEN_W];
            for (k = 0; k < 8; k++) b[k] = d[ID_W + LEN_W + 8*k +: 8];
            value  = {b[3], b[2]};
            value2 = {b[5], b[4]};
            arm    = (layout == acfd_pkg::LAYOUT_ARM);

            if (id == cmd_id && len >= acfd_pkg::MIN_CMD_LEN) begin
                kind       = acfd_pkg::KIND_CMD;
                tgt.active = 1'b1;
                if (b[0] == acfd_pkg::CMD_MULTI) begin
                    if (b[1][acfd_pkg::MASK_J0]) tgt.base = {{8{b[7][7]}}, b[7]};
                    if (b[1][acfd_pkg::MASK_J1])
                        tgt.a1 = arm ? limit(sx(value), j1_lo, j1_hi) : value;
                    if (b[1][acfd_pkg::MASK_J2])
                        tgt.a2 = arm ? limit(sx(value2), j2_lo, j2_hi) : value2;
                    if (b[1][acfd_pkg::MASK_GRIP]) begin
                        g = (b[6] > acfd_pkg::GRIP_LEVEL_MAX)
                            ? int'(acfd_pkg::GRIP_LEVEL_MAX) : int'(b[6]);
                        g = int'(acfd_pkg::GRIP_OPEN)
                            - g * GRIP_SPAN / int'(acfd_pkg::GRIP_LEVEL_MAX);
                        tgt.grip = g[VAL_W-1:0];
                    end
                end else if (b[0] == acfd_pkg::CMD_INCR) begin
                    if (arm) begin
                        if (b[1] == acfd_pkg::JNT_ONE)
                            tgt.a1 = limit(sx(tgt.a1) + sx(value), j1_lo, j1_hi);
                        else if (b[1] == acfd_pkg::JNT_TWO)
                            tgt.a2 = limit(sx(tgt.a2) + sx(value), j2_lo, j2_hi);
                        else if (b[1] == acfd_pkg::JNT_GRIP)
                            tgt.grip = tgt.grip + value;
                    end else if (b[1] >= acfd_pkg::JNT_ONE && b[1] <= acfd_pkg::JNT_GRIP) begin
                        // twin layout: joint numbers one, two and the gripper all move the gripper
                        tgt.grip = tgt.grip + value;
                    end
                end else begin
                    if (b[1] == acfd_pkg::JNT_BASE)      tgt.base = value;
                    else if (b[1] == acfd_pkg::JNT_GRIP) tgt.grip = value;
                    else if (arm) begin
                        if (b[1] == acfd_pkg::JNT_ONE)
                            tgt.a1 = limit(sx(value), j1_lo, j1_hi);
                        else if (b[1] == acfd_pkg::JNT_TWO)
                            tgt.a2 = limit(sx(value), j2_lo, j2_hi);
                    end else begin
                        if (b[1] == acfd_pkg::JNT_ONE)      tgt.left  = value;
                        else if (b[1] == acfd_pkg::JNT_TWO) tgt.right = value;
                    end
                end
            end else if (id == setup_id && len >= acfd_pkg::MIN_SETUP_LEN) begin
                kind = acfd_pkg::KIND_SETUP;
                case (b[0])
                    acfd_pkg::SETUP_HOME: begin
                        tgt.active = 1'b1;
                        if (arm) begin
                            tgt.a1   = '0;
                            tgt.a2   = '0;
                            tgt.grip = acfd_pkg::HOME_GRIP_L2;
                        end else begin
                            tgt.grip  = acfd_pkg::HOME_GRIP_L1;
                            tgt.left  = '0;
                            tgt.right = '0;
                        end
                    end
                    acfd_pkg::SETUP_SPEED:
                        if (len >= acfd_pkg::MIN_SPEED_LEN) tgt.rate = {b[2], b[1]};
                    acfd_pkg::SETUP_LOCK:   tgt.lock = 1'b1;
                    acfd_pkg::SETUP_UNLOCK: tgt.lock = 1'b0;
                    default: ;
                endcase
            end else if (id == query_id) begin
                kind = acfd_pkg::KIND_QUERY;
            end else begin
                kind = acfd_pkg::KIND_OTHER;
            end

            predicted_q.push_back({kind, 6'd0, tgt.lock, tgt.active, tgt.rate,
                                   tgt.right, tgt.left, tgt.grip, tgt.a2, tgt.a1,
                                   tgt.base});
        endfunction

        // Compare one result with the oldest prediction, field by field
        function void check_result(logic [acfd_pkg::M_TUSER_W-1:0] kind_in,
                                   logic [acfd_pkg::M_TDATA_W-1:0] d);
            logic [RES_W-1:0] want, got, mask;
            logic [VAL_W-1:0] w, a;
            string            name;
            int               k, lsb, wid;
            results_seen++;
            got = {kind_in, d};
            if (predicted_q.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("result %0d arrived with no frame pending: %h",
                             results_seen, got);
                return;
            end
            want = predicted_q.pop_front();
            for (k = 0; k < 10; k++) begin
                case (k)
                    0: begin name = "frame_kind"; lsb = acfd_pkg::M_TDATA_W; wid = 2; end
                    1: begin name = "base_target";   lsb = 0;         wid = 16; end
                    2: begin name = "first_angle";   lsb = 16;        wid = 16; end
                    3: begin name = "second_angle";  lsb = 32;        wid = 16; end
                    4: begin name = "grip_target";   lsb = 48;        wid = 16; end
                    5: begin name = "left_channel";  lsb = 64;        wid = 16; end
                    6: begin name = "right_channel"; lsb = 80;        wid = 16; end
                    7: begin name = "rate_tenths";   lsb = 96;        wid = 16; end
                    8: begin name = "servo_on";      lsb = 112;       wid = 1;  end
                    default: begin name = "locked_flag"; lsb = 113;   wid = 1;  end
                endcase
                mask = (122'd1 << wid) - 122'd1;
                w = VAL_W'((want >> lsb) & mask);
                a = VAL_W'((got >> lsb) & mask);
                if (w !== a) begin
                    failures++;
                    if (failures <= REPORT_MAX)
                        $display("result %0d: %s expected %h, got %h",
                                 results_seen, name, w, a);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT and stimulus signals
    // ------------------------------------------------------------------------
    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [acfd_pkg::S_TDATA_W-1:0]  i_s_tdata;
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    logic [acfd_pkg::M_TDATA_W-1:0]  o_m_tdata;
    logic [acfd_pkg::M_TUSER_W-1:0]  o_m_tuser;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [acfd_pkg::APB_ADDR_W-1:0] paddr;
    logic [acfd_pkg::APB_DATA_W-1:0] pwdata;
    logic [acfd_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    arm_target_scoreboard sb;
    bit                   steady_send;

    arm_command_frame_decoder_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the stream hangs
    initial begin
        #2000000;
        $display("arm_command_frame_decoder_core verification failed");
        $finish;
    end

    // Track accepted items on both stream sides
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) sb.note_frame(i_s_tdata);
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tuser, o_m_tdata);
    end

    // Result side: random ready pattern, plus one long hold-off
    initial begin : result_sink
        int run_len;
        bit held;
        run_len = 0;
        held    = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && sb.results_seen >= 40) begin
                held = 1'b1;
                i_m_tready <= 1'b0;
                repeat (400) @(negedge i_clk);
                run_len = 0;
            end else if (run_len > 0) begin
                run_len--;
            end else if ($urandom_range(0, 3) != 0) begin
                i_m_tready <= 1'b1;
                run_len = $urandom_range(0, ($urandom_range(0, 9) == 0) ? 40 : 12);
            end else begin
                i_m_tready <= 1'b0;
                run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(0, 2);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks and frame builders
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (steady_send) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [acfd_pkg::S_TDATA_W-1:0] pack_frame(
        input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
        input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
        input logic [7:0] b3, input logic [7:0] b4, input logic [7:0] b5,
        input logic [7:0] b6, input logic [7:0] b7);
        return {1'b0, b7, b6, b5, b4, b3, b2, b1, b0, len, id};
    endfunction

    // Angle values: mostly near the usual limits, some extremes, some random
    function automatic logic [VAL_W-1:0] rand_angle();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return VAL_W'($urandom_range(0, 2400)) - 16'd1200;
        if (r < 7) begin
            case ($urandom_range(0, 3))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'hFFFF;
                default: return 16'h0000;
            endcase
        end
        return VAL_W'($urandom);
    endfunction

    function automatic logic [acfd_pkg::S_TDATA_W-1:0] rand_frame();
        logic [ID_W-1:0]  id;
        logic [LEN_W-1:0] len;
        logic [7:0]       b [0:7];
        logic [VAL_W-1:0] v;
        int               k, r;
        for (k = 0; k < 8; k++) b[k] = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 55)      id = sb.cmd_id;
        else if (r < 75) id = sb.setup_id;
        else if (r < 85) id = sb.query_id;
        else             id = ID_W'($urandom);
        len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom) : 4'd8;
        if (id == sb.cmd_id) begin
            r = $urandom_range(0, 99);
            if (r < 35)      b[0] = acfd_pkg::CMD_MULTI;
            else if (r < 70) b[0] = acfd_pkg::CMD_INCR;
            else if (r < 90) b[0] = 8'h00;
            if (b[0] != acfd_pkg::CMD_MULTI && $urandom_range(0, 9) < 8)
                b[1] = 8'($urandom_range(0, 3));
            v = rand_angle();
            b[2] = v[7:0];
            b[3] = v[15:8];
            v = rand_angle();
            b[4] = v[7:0];
            b[5] = v[15:8];
        end else if (id == sb.setup_id) begin
            if ($urandom_range(0, 4) != 0) b[0] = 8'($urandom_range(1, 4));
            if ($urandom_range(0, 4) == 0) len = LEN_W'($urandom_range(0, 8));
        end
        return pack_frame(id, len, b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]);
    endfunction

    // Offer one item after a random gap and hold it until accepted
    task automatic send_frame(input logic [acfd_pkg::S_TDATA_W-1:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_cmd(input logic [7:0] code, input logic [7:0] sel,
                            input logic [VAL_W-1:0] v, input logic [VAL_W-1:0] v2,
                            input logic [7:0] b6, input logic [7:0] b7);
        send_frame(pack_frame(sb.cmd_id, 4'd8, code, sel, v[7:0], v[15:8],
                              v2[7:0], v2[15:8], b6, b7));
    endtask

    task automatic send_setup(input logic [LEN_W-1:0] len, input logic [7:0] code,
                              input logic [7:0] b1, input logic [7:0] b2);
        send_frame(pack_frame(sb.setup_id, len, code, b1, b2, 8'hA5, 8'h5A,
                              8'hFF, 8'h00, 8'h81));
    endtask

    // APB write with random bits above the register width
    task automatic reg_write(input logic [2:0] idx, input logic [VAL_W-1:0] val,
                             input int wid);
        logic [acfd_pkg::APB_DATA_W-1:0] d, m;
        m = (32'd1 << wid) - 32'd1;
        d = ($urandom & ~m) | (acfd_pkg::APB_DATA_W'(val) & m);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= d;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_reg(idx, d);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stop offering and wait for every pending result
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic apply_setting(input int p);
        logic [ID_W-1:0]  c, s, q;
        logic [1:0]       lay;
        logic [VAL_W-1:0] lo1, hi1, lo2, hi2;
        c   = ID_W'($urandom);
        s   = ID_W'($urandom);
        q   = ID_W'($urandom);
        lay = ($urandom_range(0, 1) != 0) ? acfd_pkg::LAYOUT_ARM : LAYOUT_TWIN;
        lo1 = -VAL_W'($urandom_range(0, 1500));
        hi1 = VAL_W'($urandom_range(0, 1500));
        lo2 = -VAL_W'($urandom_range(0, 1500));
        hi2 = VAL_W'($urandom_range(0, 1500));
        case (p)
            0: lay = acfd_pkg::LAYOUT_ARM;
            1: lay = LAYOUT_TWIN;
            2: begin
                c   = '0;
                s   = '1;
                lo1 = 16'h8000;
                hi1 = 16'h7FFF;
                lo2 = 16'h8000;
                hi2 = 16'h7FFF;
                lay = acfd_pkg::LAYOUT_ARM;
            end
            3: begin
                // minimum above maximum
                lo1 = 16'd500;
                hi1 = -16'd500;
                lo2 = 16'h7FFF;
                hi2 = 16'h8000;
                lay = acfd_pkg::LAYOUT_ARM;
            end
            4: begin
                // one id for all kinds: command beats setup beats query
                s   = c;
                q   = c;
                lo1 = '0;
                hi1 = '0;
                lay = acfd_pkg::LAYOUT_ARM;
            end
            5: begin
                c   = '1;
                s   = '0;
                lay = LAYOUT_TWIN;
            end
            default: ;
        endcase
        reg_write(acfd_pkg::REG_COMMAND_ID, VAL_W'(c), ID_W);
        reg_write(acfd_pkg::REG_SETUP_ID, VAL_W'(s), ID_W);
        reg_write(acfd_pkg::REG_QUERY_ID, VAL_W'(q), ID_W);
        reg_write(acfd_pkg::REG_LAYOUT, VAL_W'(lay), 2);
        reg_write(acfd_pkg::REG_J1_MIN, lo1, VAL_W);
        reg_write(acfd_pkg::REG_J1_MAX, hi1, VAL_W);
        reg_write(acfd_pkg::REG_J2_MIN, lo2, VAL_W);
        reg_write(acfd_pkg::REG_J2_MAX, hi2, VAL_W);
        steady_send = (p == 2 || p == 5);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int p, n;
        sb          = new();
        steady_send = 1'b0;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_m_tready  = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed frames under the reset settings
        send_frame(pack_frame(acfd_pkg::RST_QUERY_ID, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00,
                              8'h00, 8'h00, 8'h00, 8'h00));
        send_frame(pack_frame(11'h7FF, 4'hF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                              8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_frame(pack_frame(acfd_pkg::RST_COMMAND_ID, 4'd3, acfd_pkg::CMD_MULTI, 8'h0F,
                              8'h10, 8'h00, 8'h10, 8'h00, 8'h20, 8'h7F));
        send_frame(pack_frame(acfd_pkg::RST_SETUP_ID, 4'd0, acfd_pkg::SETUP_LOCK, 8'h00,
                              8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_cmd(8'h00, acfd_pkg::JNT_ONE, 16'd1000, 16'h0000, 8'h00, 8'h00);
        send_cmd(8'hFF, acfd_pkg::JNT_ONE, 16'h8000, 16'h0000, 8'h00, 8'h00);
        send_cmd(8'h00, acfd_pkg::JNT_TWO, 16'h7FFF, 16'h0000, 8'h00, 8'h00);
        send_cmd(8'h00, acfd_pkg::JNT_BASE, 16'h8000, 16'h0000, 8'h00, 8'h00);
        send_cmd(8'h00, acfd_pkg::JNT_GRIP, 16'hFFFF, 16'h0000, 8'h00, 8'h00);
        send_cmd(8'h00, 8'd7, 16'h1234, 16'h0000, 8'h00, 8'h00);
        send_cmd(acfd_pkg::CMD_MULTI, 8'h0F, 16'd500, 16'hFC18, 8'hFF, 8'h80);
        send_cmd(acfd_pkg::CMD_MULTI, 8'hF0, 16'h7FFF, 16'h7FFF, 8'h00, 8'h7F);
        send_cmd(acfd_pkg::CMD_MULTI, 8'h09, 16'h0000, 16'h0000, 8'd200, 8'h7F);
        send_cmd(acfd_pkg::CMD_MULTI, 8'h08, 16'h0000, 16'h0000, 8'd0, 8'h00);
        send_cmd(acfd_pkg::CMD_INCR, acfd_pkg::JNT_ONE, 16'd800, 16'h0000, 8'h00, 8'h00);
        send_cmd(acfd_pkg::CMD_INCR, acfd_pkg::JNT_ONE, 16'hF830, 16'h0000, 8'h00, 8'h00);
        send_cmd(acfd_pkg::CMD_INCR, acfd_pkg::JNT_TWO, 16'h7FFF, 16'h0000, 8'h00, 8'h00);
        send_cmd(acfd_pkg::CMD_INCR, acfd_pkg::JNT_GRIP, 16'hFFFF, 16'h0000, 8'h00, 8'h00);
        send_cmd(acfd_pkg::CMD_INCR, 8'hFF, 16'h0100, 16'h0000, 8'h00, 8'h00);
        send_setup(4'd1, acfd_pkg::SETUP_HOME, 8'h00, 8'h00);
        send_setup(4'd2, acfd_pkg::SETUP_SPEED, 8'h01, 8'h80);
        send_setup(4'd3, acfd_pkg::SETUP_SPEED, 8'h01, 8'h80);
        send_setup(4'd8, acfd_pkg::SETUP_LOCK, 8'h00, 8'h00);
        send_setup(4'd8, acfd_pkg::SETUP_UNLOCK, 8'h00, 8'h00);
        send_setup(4'd8, 8'hFF, 8'hFF, 8'hFF);
        send_frame(pack_frame(acfd_pkg::RST_COMMAND_ID, 4'hF, acfd_pkg::CMD_INCR,
                              acfd_pkg::JNT_ONE, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00,
                              8'h00));

        // Directed frames in the twin gripper layout: no clamping
        drain();
        reg_write(acfd_pkg::REG_LAYOUT, VAL_W'(LAYOUT_TWIN), 2);
        send_cmd(acfd_pkg::CMD_INCR, acfd_pkg::JNT_ONE, 16'h4000, 16'h0000, 8'h00, 8'h00);
        send_cmd(acfd_pkg::CMD_INCR, acfd_pkg::JNT_TWO, 16'hC000, 16'h0000, 8'h00, 8'h00);
        send_cmd(acfd_pkg::CMD_INCR, acfd_pkg::JNT_GRIP, 16'hFFFF, 16'h0000, 8'h00, 8'h00);
        send_cmd(8'h00, acfd_pkg::JNT_ONE, 16'h8000, 16'h0000, 8'h00, 8'h00);
        send_cmd(8'h00, acfd_pkg::JNT_TWO, 16'h7FFF, 16'h0000, 8'h00, 8'h00);
        send_cmd(acfd_pkg::CMD_MULTI, 8'h06, 16'h7FFF, 16'h8000, 8'h00, 8'h00);
        send_setup(4'd8, acfd_pkg::SETUP_HOME, 8'h00, 8'h00);

        // Random frames under a series of register settings
        for (p = 0; p < PHASES; p++) begin
            drain();
            apply_setting(p);
            for (n = 0; n < PHASE_FRAMES; n++) send_frame(rand_frame());
        end

        // Wait out the last results, then give the verdict
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("arm_command_frame_decoder_core verification clean");
        end else begin
            $display("arm_command_frame_decoder_core verification failed");
        end
        $finish;
    end

endmodule
